[rtl/dsg_pkg.sv]
// Shared widths, item and result types for the softened gravity summation block.
`default_nettype none
package dsg_pkg;
    localparam int ACC_W   = 48;             // accumulator width
    localparam int OUT_W   = 48;             // width of the emitted sums
    localparam int POS_W   = 32;             // Q16.16 position
    localparam int D_W     = POS_W + 1;      // position difference
    localparam int M_W     = 32;             // Q16.16 mass
    localparam int S_W     = 50;             // softened squared distance
    localparam int SQ_W    = S_W + 12;       // square-root operand (even)
    localparam int R_W     = SQ_W / 2;       // square root
    localparam int DEN_W   = S_W + R_W;      // divisor
    localparam int NUM_SH  = 22;             // numerator scaling shift
    localparam int NUM_W   = D_W + M_W + NUM_SH;
    localparam int REM_W   = DEN_W + 1;      // divider remainder
    localparam int DIV_CW  = $clog2(ACC_W + 1);
    localparam int MUL_W   = 33;             // shared multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SPLIT   = S_W / 2;        // low half of s in the divisor product
    localparam int QD      = 2;              // item queue depth
    localparam int QP_W    = 1;              // item queue pointer width

    typedef struct packed {
        logic [2:0][D_W-1:0] adx;   // |target - source| per axis
        logic [2:0]          sub;   // 1: term is subtracted (difference positive)
        logic [M_W-1:0]      mass;
        logic                skip;
        logic                first;
        logic                last;
    } t_item;

    typedef struct packed {
        logic [OUT_W-1:0] ax;
        logic [OUT_W-1:0] ay;
        logic [OUT_W-1:0] az;
        logic             sat;
    } t_res;
endpackage
`default_nettype wire

[rtl/dsg_front.sv]
// Front end: take requests, form per-axis distances and queue them for the back end.
`default_nettype none
module dsg_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          push,
    output logic                         full,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_target_x,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_target_y,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_target_z,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_source_x,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_source_y,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_source_z,
    input  wire         [dsg_pkg::M_W-1:0]   i_source_mass,
    input  wire                          i_is_self,
    input  wire                          i_first_source,
    input  wire                          i_last_source,
    output logic                         o_avail,
    output dsg_pkg::t_item               o_item,
    input  wire                          i_take
);
    dsg_pkg::t_item r_q [dsg_pkg::QD];
    logic [dsg_pkg::QP_W-1:0] r_wp, r_rp;
    logic [dsg_pkg::QP_W:0]   r_cnt;
    dsg_pkg::t_item w_new;
    logic w_push, w_pop;
    logic signed [dsg_pkg::D_W-1:0] w_dx [3];
    logic signed [dsg_pkg::POS_W-1:0] w_t [3];
    logic signed [dsg_pkg::POS_W-1:0] w_s [3];

    assign w_t[0] = i_target_x;
    assign w_t[1] = i_target_y;
    assign w_t[2] = i_target_z;
    assign w_s[0] = i_source_x;
    assign w_s[1] = i_source_y;
    assign w_s[2] = i_source_z;

    always_comb begin
        w_new = '0;
        for (int i = 0; i < 3; i++) begin
            w_dx[i] = dsg_pkg::D_W'(w_t[i]) - dsg_pkg::D_W'(w_s[i]);
            w_new.adx[i] = w_dx[i][dsg_pkg::D_W-1] ? dsg_pkg::D_W'(-w_dx[i])
                                                  : dsg_pkg::D_W'(w_dx[i]);
            w_new.sub[i] = !w_dx[i][dsg_pkg::D_W-1] && (w_dx[i] != '0);
        end
        w_new.mass  = i_source_mass;
        w_new.skip  = i_is_self;
        w_new.first = i_first_source;
        w_new.last  = i_last_source;
    end

    assign full    = (r_cnt == (dsg_pkg::QP_W+1)'(dsg_pkg::QD));
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign w_push  = push && !full;
    assign w_pop   = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (dsg_pkg::QP_W+1)'(w_push) - (dsg_pkg::QP_W+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

[rtl/dsg_isqrt.sv]
// Bit-pair integer square root, one result bit per cycle.
`default_nettype none
module dsg_isqrt (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [dsg_pkg::SQ_W-1:0]   i_v,
    output logic [dsg_pkg::R_W-1:0]    o_root,
    output logic                       o_done
);
    logic [dsg_pkg::SQ_W-1:0] r_v, r_res, r_bit;
    logic                     r_busy, r_done;
    logic [dsg_pkg::SQ_W:0]   w_trial;

    assign w_trial = (dsg_pkg::SQ_W+1)'(r_res) + (dsg_pkg::SQ_W+1)'(r_bit);
    assign o_root  = dsg_pkg::R_W'(r_res);
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_v;
            r_res <= '0;
            r_bit <= dsg_pkg::SQ_W'(1) << (dsg_pkg::SQ_W - 2);
        end else if (r_busy) begin
            if ((dsg_pkg::SQ_W+1)'(r_v) >= w_trial) begin
                r_v   <= r_v - dsg_pkg::SQ_W'(w_trial);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/dsg_div.sv]
// Restoring divider with a saturated quotient of ACC_W bits.
`default_nettype none
module dsg_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire  [dsg_pkg::NUM_W-1:0]   i_num,
    input  wire  [dsg_pkg::DEN_W-1:0]   i_den,
    output logic [dsg_pkg::ACC_W-1:0]   o_q,
    output logic                        o_ovf,
    output logic                        o_done
);
    logic [dsg_pkg::REM_W-1:0]  r_rem, w_hi, w_t, w_den;
    logic [dsg_pkg::ACC_W-1:0]  r_lo, r_q;
    logic [dsg_pkg::DEN_W-1:0]  r_den;
    logic [dsg_pkg::DIV_CW-1:0] r_cnt;
    logic                       r_busy, r_done, r_ovf;

    assign w_hi  = dsg_pkg::REM_W'(i_num >> dsg_pkg::ACC_W);
    assign w_den = dsg_pkg::REM_W'(r_den);
    assign w_t   = {r_rem[dsg_pkg::REM_W-2:0], r_lo[dsg_pkg::ACC_W-1]};
    assign o_q   = r_q;
    assign o_ovf = r_ovf;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= w_hi;
            r_lo  <= i_num[dsg_pkg::ACC_W-1:0];
            r_cnt <= dsg_pkg::DIV_CW'(dsg_pkg::ACC_W);
            // quotient would not fit: clamp to all ones
            r_ovf <= (w_hi >= dsg_pkg::REM_W'(i_den));
            r_q   <= (w_hi >= dsg_pkg::REM_W'(i_den)) ? '1 : '0;
        end else if (r_busy) begin
            r_lo  <= r_lo << 1;
            r_cnt <= r_cnt - 1'b1;
            if (w_t >= w_den) begin
                r_rem <= w_t - w_den;
                r_q   <= {r_q[dsg_pkg::ACC_W-2:0], 1'b1};
            end else begin
                r_rem <= w_t;
                r_q   <= {r_q[dsg_pkg::ACC_W-2:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_hi >= dsg_pkg::REM_W'(i_den)) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_cnt == dsg_pkg::DIV_CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/dsg_back.sv]
// Back end: sequence the pair math for one queued item and keep the saturating sums.
`default_nettype none
module dsg_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire  [31:0]                i_eps2,
    input  wire                        i_avail,
    input  dsg_pkg::t_item             i_item,
    output logic                       o_take,
    output logic                       o_res_valid,
    output dsg_pkg::t_res              o_res,
    input  wire                        i_res_take
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_DEN  = 4'd4;
    localparam logic [3:0] S_NUM  = 4'd5;
    localparam logic [3:0] S_NUMW = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    localparam logic signed [dsg_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(dsg_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [dsg_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(dsg_pkg::ACC_W-1){1'b0}}};

    logic [3:0]                       r_state;
    logic [1:0]                       r_cnt, r_ax;
    dsg_pkg::t_item                   r_item;
    logic [dsg_pkg::S_W-1:0]          r_s;
    logic [dsg_pkg::R_W-1:0]          r_root;
    logic [dsg_pkg::PROD_W-1:0]       r_prod, r_p0;
    logic [dsg_pkg::DEN_W-1:0]        r_den;
    logic signed [dsg_pkg::ACC_W-1:0] r_acc [3];
    logic                             r_sat;

    logic [dsg_pkg::MUL_W-1:0]        w_a, w_b;
    logic                             w_sq_start, w_sq_done, w_div_start, w_div_done, w_div_ovf;
    logic [dsg_pkg::R_W-1:0]          w_root;
    logic [dsg_pkg::ACC_W-1:0]        w_q;
    logic [dsg_pkg::NUM_W-1:0]        w_num;
    logic signed [dsg_pkg::ACC_W+1:0] w_ext, w_qe, w_sum;
    logic signed [dsg_pkg::ACC_W-1:0] w_new;
    logic                             w_add_sat;

    // shared multiplier operand select
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            S_SQ: begin
                if (r_cnt != 2'd3) begin
                    w_a = r_item.adx[r_cnt];
                    w_b = r_item.adx[r_cnt];
                end
            end
            S_DEN: begin
                w_a = (r_cnt == 2'd0) ? dsg_pkg::MUL_W'(r_s[dsg_pkg::SPLIT-1:0])
                                      : dsg_pkg::MUL_W'(r_s[dsg_pkg::S_W-1:dsg_pkg::SPLIT]);
                w_b = dsg_pkg::MUL_W'(r_root);
            end
            S_NUM: begin
                w_a = dsg_pkg::MUL_W'(r_item.mass);
                w_b = r_item.adx[r_ax];
            end
            default: begin
            end
        endcase
    end

    assign w_sq_start  = (r_state == S_CHK) && (r_s != '0);
    assign w_div_start = (r_state == S_NUMW);
    assign w_num       = dsg_pkg::NUM_W'(r_prod) << dsg_pkg::NUM_SH;

    dsg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_v     (dsg_pkg::SQ_W'(r_s) << 12),
        .o_root  (w_root),
        .o_done  (w_sq_done)
    );

    dsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_q     (w_q),
        .o_ovf   (w_div_ovf),
        .o_done  (w_div_done)
    );

    // saturating add of one term into the current axis
    always_comb begin
        w_ext = (dsg_pkg::ACC_W+2)'(r_acc[r_ax]);
        w_qe  = $signed({2'b00, w_q});
        w_sum = r_item.sub[r_ax] ? (w_ext - w_qe) : (w_ext + w_qe);
        w_add_sat = (w_sum[dsg_pkg::ACC_W+1] != w_sum[dsg_pkg::ACC_W])
                 || (w_sum[dsg_pkg::ACC_W] != w_sum[dsg_pkg::ACC_W-1]);
        if (w_add_sat) begin
            w_new = w_sum[dsg_pkg::ACC_W+1] ? ACC_MIN : ACC_MAX;
        end else begin
            w_new = w_sum[dsg_pkg::ACC_W-1:0];
        end
    end

    assign o_take      = (r_state == S_IDLE) && i_avail;
    assign o_res_valid = (r_state == S_FIN) && r_item.last;
    assign o_res.ax    = dsg_pkg::OUT_W'(r_acc[0]);
    assign o_res.ay    = dsg_pkg::OUT_W'(r_acc[1]);
    assign o_res.az    = dsg_pkg::OUT_W'(r_acc[2]);
    assign o_res.sat   = r_sat;

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    r_item <= i_item;
                    r_s    <= dsg_pkg::S_W'(i_eps2);
                    r_cnt  <= '0;
                end
            end
            S_SQ: begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt != 2'd0) begin
                    r_s <= r_s + dsg_pkg::S_W'(r_prod >> 16);
                end
            end
            S_SQRT: begin
                r_root <= w_root;
                r_cnt  <= '0;
            end
            S_DEN: begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 2'd1) begin
                    r_p0 <= r_prod;
                end
                if (r_cnt == 2'd2) begin
                    r_den <= dsg_pkg::DEN_W'(r_p0) + (dsg_pkg::DEN_W'(r_prod) << dsg_pkg::SPLIT);
                end
            end
            default: begin
            end
        endcase

        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= '0;
            r_sat   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        if (i_item.first) begin
                            r_sat <= 1'b0;
                            for (int i = 0; i < 3; i++) begin
                                r_acc[i] <= '0;
                            end
                        end
                        r_state <= i_item.skip ? S_FIN : S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt == 2'd3) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    // zero denominator: add nothing
                    r_state <= (r_s == '0) ? S_FIN : S_SQRT;
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    if (r_cnt == 2'd2) begin
                        r_ax    <= '0;
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_state <= S_NUMW;
                end
                S_NUMW: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_acc[r_ax] <= w_new;
                        if (w_add_sat || w_div_ovf) begin
                            r_sat <= 1'b1;
                        end
                        if (r_ax == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= S_NUM;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_item.last || i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/direct_softened_gravity_sum.sv]
// Top level: direct softened gravity summation for one target particle.
//
// Use:
//   Input is a queue: drive the target and one source per request with push;
//   a request is taken at a clock edge where push is high and full is low.
//   Mark the first source of a run with first_source (clears the sums and the
//   saturation flag) and the last with last_source (one result follows).
//   Results are a queue too: while empty is low the summed acceleration and
//   the saturation flag are on o_accel_* / o_saturated; pop takes them.
//   softening_sq is written through i_cfg_we / i_cfg_wdata while idle.
// Sequencing (one request at a time in a single shared sequencer):
//   a self request goes from take to finish, a zero softened distance stops
//   after the check, any other runs: take, squaring of the axis distances,
//   check, the 31-step square root, the divisor product, per axis a multiply
//   and a 48-step restoring division (skipped when the quotient overflows),
//   and finish. The last request's result is registered into the output slot
//   once that slot is free or being popped. Two requests queue in front of the
//   sequencer, so the sender sees full only when both slots are taken.
// Reset: synchronous, active low; sums, flag and both queues clear, and
//   softening_sq returns to 655. A stalled result holds until popped; the
//   sequencer then waits at the next last request.
`default_nettype none
module direct_softened_gravity_sum (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              push,
    output logic                             full,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_target_x,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_target_y,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_target_z,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_source_x,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_source_y,
    input  wire  signed [dsg_pkg::POS_W-1:0] i_source_z,
    input  wire         [dsg_pkg::M_W-1:0]   i_source_mass,
    input  wire                              i_is_self,
    input  wire                              i_first_source,
    input  wire                              i_last_source,
    output logic                             empty,
    input  wire                              pop,
    output logic signed [dsg_pkg::OUT_W-1:0] o_accel_x,
    output logic signed [dsg_pkg::OUT_W-1:0] o_accel_y,
    output logic signed [dsg_pkg::OUT_W-1:0] o_accel_z,
    output logic                             o_saturated,
    input  wire                              i_cfg_we,
    input  wire         [31:0]               i_cfg_wdata
);
    logic [31:0]    r_eps2;
    logic           w_avail, w_take, w_res_valid, w_res_take;
    dsg_pkg::t_item w_item;
    dsg_pkg::t_res  w_res, r_out;
    logic           r_out_valid;

    // front: accept and queue requests
    dsg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_target_z     (i_target_z),
        .i_source_x     (i_source_x),
        .i_source_y     (i_source_y),
        .i_source_z     (i_source_z),
        .i_source_mass  (i_source_mass),
        .i_is_self      (i_is_self),
        .i_first_source (i_first_source),
        .i_last_source  (i_last_source),
        .o_avail        (w_avail),
        .o_item         (w_item),
        .i_take         (w_take)
    );

    // back: pair math and saturating sums
    dsg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eps2      (r_eps2),
        .i_avail     (w_avail),
        .i_item      (w_item),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take)
    );

    // load the output slot when it is free or being popped this cycle
    assign w_res_take = w_res_valid && (!r_out_valid || pop);

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
        if (!i_rst_n) begin
            r_eps2      <= 32'd655;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eps2 <= i_cfg_wdata;
            end
            if (w_res_take) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign empty       = !r_out_valid;
    assign o_accel_x   = r_out.ax;
    assign o_accel_y   = r_out.ay;
    assign o_accel_z   = r_out.az;
    assign o_saturated = r_out.sat;

    // a result handed over by the back end is visible next cycle
    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_take |=> !empty)
        else $error("result taken from back end but output empty");

    // reset empties the result side and frees the request side
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // the back end never drops a result while the output slot is held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_take && !empty) |-> pop)
        else $error("output slot overwritten before pop");
endmodule
`default_nettype wire
